>>> hdl/mae_pkg.sv
// Package for the motion activity estimator: shared types and fixed constants.
// Used by every module of the block; no dependencies of its own.
`default_nettype none
package mae_pkg;

    localparam int PERIOD_W  = 8;
    localparam int DUTY_W    = 5;
    localparam int ACT_W     = 8;

    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [DUTY_W-1:0]   t_duty;
    typedef logic [ACT_W-1:0]    t_act;

    localparam t_period PERIOD_RST = 8'd15;
    localparam t_duty   DUTY_RST   = 5'd2;
    localparam t_duty   DUTY_MUL   = 5'd13;
    localparam t_duty   DUTY_OFF   = 5'd3;
    localparam t_act    ACT_MAX    = 8'd255;

    typedef struct packed {
        logic advance;
        logic is_low;
        logic wrap;
    } t_win_ctl;

endpackage
`default_nettype wire

>>> hdl/mae_ifs.sv
// Valid/ready channel interfaces for the motion activity estimator.
// Depends on mae_pkg for the result field types.
`default_nettype none
interface mae_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] accel_x;
    logic [SAMPLE_BITS-1:0] accel_y;
    logic [SAMPLE_BITS-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface mae_out_if;
    logic           valid;
    logic           ready;
    mae_pkg::t_act  activity;
    logic           activity_valid;
    mae_pkg::t_duty drive_duty;

    modport source (output valid, output activity, output activity_valid, output drive_duty,
                    input ready);
    modport sink   (input valid, input activity, input activity_valid, input drive_duty,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/mae_axis.sv
// One axis: low/high half-window sums and the scaled magnitude of their difference.
// Depends on mae_pkg (t_win_ctl).
`default_nettype none
module mae_axis #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW),
    parameter int DIV_L       = $clog2(2 * WINDOW),
    parameter int MAG_W       = SUM_W - DIV_L + 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  mae_pkg::t_win_ctl      i_ctl,
    input  wire [SAMPLE_BITS-1:0]  i_sample,
    output logic [MAG_W-1:0]       o_mag
);
    import mae_pkg::*;

    localparam int          DIVISOR = 2 * WINDOW;
    localparam int          MULT_W  = SUM_W + 1;
    localparam int          SHIFT   = SUM_W + DIV_L;
    localparam logic [63:0] MULT64  = ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1)
                                      / 64'(DIVISOR);
    localparam logic [MULT_W-1:0] MULT = MULT64[MULT_W-1:0];

    logic [SUM_W-1:0]          r_low, r_high;
    logic [SUM_W-1:0]          n_low, n_high;
    logic [SUM_W:0]            diff;
    logic [SUM_W-1:0]          diff_abs;
    logic [SUM_W+MULT_W-1:0]   prod;

    always_comb begin
        n_low  = r_low  + (i_ctl.is_low ? SUM_W'(i_sample) : '0);
        n_high = r_high + (i_ctl.is_low ? '0 : SUM_W'(i_sample));
        diff   = {1'b0, n_high} - {1'b0, n_low};
        if (diff[SUM_W]) begin
            diff_abs = SUM_W'(-diff);
        end else begin
            diff_abs = diff[SUM_W-1:0];
        end
        prod  = (SUM_W+MULT_W)'(diff_abs) * (SUM_W+MULT_W)'(MULT);
        o_mag = prod[SHIFT +: MAG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
        end else if (i_ctl.advance) begin
            if (i_ctl.wrap) begin
                r_low  <= '0;
                r_high <= '0;
            end else begin
                r_low  <= n_low;
                r_high <= n_high;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/mae_duty.sv
// Drive duty generator: countdown reloaded from the period register flips the phase.
// Depends on mae_pkg (types and duty constants).
`default_nettype none
module mae_duty (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_advance,
    input  mae_pkg::t_period i_period,
    output mae_pkg::t_duty   o_duty_next
);
    import mae_pkg::*;

    t_period r_count, n_count;
    logic    r_phase, n_phase;
    t_duty   r_duty, n_duty;
    t_period dec;

    always_comb begin
        dec     = r_count - 8'd1;
        n_count = dec;
        n_phase = r_phase;
        n_duty  = r_duty;
        if (dec == '0) begin
            n_phase = ~r_phase;
            n_duty  = DUTY_OFF + (n_phase ? DUTY_MUL : '0);
            n_count = i_period;
        end
        o_duty_next = n_duty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= PERIOD_RST;
            r_phase <= 1'b1;
            r_duty  <= DUTY_RST;
        end else if (i_advance) begin
            r_count <= n_count;
            r_phase <= n_phase;
            r_duty  <= n_duty;
        end
    end

endmodule
`default_nettype wire

>>> hdl/motion_activity_estimator.sv
// Motion activity estimator top level: input register, window control, result register.
// Depends on mae_pkg, mae_ifs (channels), mae_axis and mae_duty.
//
// Usage: each item on i_sample is one timer tick carrying x/y/z accelerometer codes.
// Every accepted item yields exactly one result item on o_result: the held activity,
// a flag set when this tick closed a window of WINDOW ticks, and the drive duty.
// Path: an accepted item is held in the input register, then its result enters the
// result register. Throughput: one item per cycle while o_result.ready stays high;
// the next sums, the constant division and the saturating add are all combinational.
// Stall: when o_result.ready is low a full result register holds; the input register
// still takes one more item, after which i_sample.ready drops until the result moves.
// Reset (synchronous, active low): sums cleared, window position 0, activity 0,
// countdown 15, phase 1, duty 2, r_period 15, both registers empty. Users must set
// r_period via i_cfg_we/i_cfg_wdata only while no item is in flight; not enforced.
`default_nettype none
module motion_activity_estimator #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 10
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    mae_in_if.sink             i_sample,
    mae_out_if.source          o_result,
    input  wire                i_cfg_we,
    input  mae_pkg::t_period   i_cfg_wdata
);
    import mae_pkg::*;

    localparam int POS_W = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
    localparam int DIV_L = $clog2(2 * WINDOW);
    localparam int MAG_W = SUM_W - DIV_L + 1;
    localparam int TOT_W = MAG_W + 2;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [POS_W-1:0] POS_HALF = POS_W'(WINDOW / 2);

    t_period                r_period;
    logic                   r_s1_valid;
    logic [SAMPLE_BITS-1:0] r_x, r_y, r_z;
    logic [POS_W-1:0]       r_pos, n_pos;
    t_act                   r_held_act, n_act;
    logic                   r_out_valid;
    t_act                   r_out_act;
    logic                   r_out_act_valid;
    t_duty                  r_out_duty;

    logic                   advance;
    t_win_ctl               ctl;
    logic [MAG_W-1:0]       mag_x, mag_y, mag_z;
    logic [TOT_W-1:0]       total;
    t_duty                  duty_next;

    assign advance        = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_s1_valid || advance;

    always_comb begin
        n_pos       = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        ctl.advance = advance;
        ctl.is_low  = n_pos < POS_HALF;
        ctl.wrap    = n_pos == '0;
        total       = TOT_W'(mag_x) + TOT_W'(mag_y) + TOT_W'(mag_z);
        n_act       = r_held_act;
        if (ctl.wrap) begin
            n_act = (total > TOT_W'(ACT_MAX)) ? ACT_MAX : total[ACT_W-1:0];
        end
    end

    mae_axis #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_sample(r_x), .o_mag(mag_x)
    );
    mae_axis #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_sample(r_y), .o_mag(mag_y)
    );
    mae_axis #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_axis_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .i_sample(r_z), .o_mag(mag_z)
    );

    mae_duty u_duty (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_advance(advance),
        .i_period(r_period), .o_duty_next(duty_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_x <= i_sample.accel_x;
            r_y <= i_sample.accel_y;
            r_z <= i_sample.accel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_held_act <= '0;
        end else if (advance) begin
            r_pos      <= n_pos;
            r_held_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_act       <= n_act;
            r_out_act_valid <= ctl.wrap;
            r_out_duty      <= duty_next;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.activity       = r_out_act;
    assign o_result.activity_valid = r_out_act_valid;
    assign o_result.drive_duty     = r_out_duty;

endmodule
`default_nettype wire

>>> dv/motion_activity_estimator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for motion_activity_estimator: directed and random samples
// against an in-bench activity and duty predictor. Depends on mae_pkg and mae_ifs.
module motion_activity_estimator_tb;
    import mae_pkg::*;

    localparam int SAMPLE_BITS = 10;
    localparam int WIN_LEN     = 10;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 3000;

    typedef logic [SAMPLE_BITS-1:0] t_code;

    typedef struct packed {
        t_code x;
        t_code y;
        t_code z;
    } t_sample;

    typedef struct packed {
        t_act  activity;
        logic  activity_valid;
        t_duty drive_duty;
    } t_reading;

    typedef struct packed {
        t_sample  smp;
        logic     typed;
        t_reading want;
    } t_row;

    localparam t_code CODE_MAX = t_code'((1 << SAMPLE_BITS) - 1);

    localparam t_row DIRECTED [25] = '{
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd0,   1'b0, 5'd2}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b1, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd255, 1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd255, 1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd255, 1'b0, 5'd2}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd255, 1'b0, 5'd2}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b0, 5'd3}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b0, 5'd3}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b0, 5'd3}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b0, 5'd3}},
        '{'{10'd0, 10'd0, 10'd0},          1'b1, '{8'd255, 1'b0, 5'd3}},
        '{'{CODE_MAX, CODE_MAX, CODE_MAX}, 1'b1, '{8'd255, 1'b1, 5'd3}},
        '{'{10'd1, 10'd2, 10'd4},          1'b0, '0},
        '{'{10'd512, 10'd256, 10'd128},    1'b0, '0},
        '{'{CODE_MAX, 10'd0, 10'd511},     1'b0, '0},
        '{'{10'h155, 10'h2AA, CODE_MAX},   1'b0, '0},
        '{'{10'h2AA, 10'h155, 10'd0},      1'b0, '0}
    };

    logic    i_clk;
    logic    i_rst_n;
    logic    i_cfg_we;
    t_period i_cfg_wdata;

    mae_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_if ();
    mae_out_if result_if ();

    motion_activity_estimator #(
        .WINDOW      (WIN_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    logic [3:0]  win_pos;
    logic [12:0] low_sum  [3];
    logic [12:0] high_sum [3];
    t_act        act_held;
    t_period     countdown;
    t_period     period;
    logic        phase;
    t_duty       duty_held;

    t_reading expected_readings [$];
    int       error_count = 0;
    int       idle_cycles = 0;
    logic     hold_off_req = 1'b0;

    logic [7:0] stall_pat;
    logic [2:0] pat_idx = '0;
    int         stall_mode = 0;
    int         mode_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_estimator();
        win_pos = '0;
        for (int i = 0; i < 3; i++) begin
            low_sum[i]  = '0;
            high_sum[i] = '0;
        end
        act_held  = '0;
        countdown = PERIOD_RST;
        period    = PERIOD_RST;
        phase     = 1'b1;
        duty_held = DUTY_RST;
    endfunction

    function automatic t_reading advance_estimator(input t_sample smp);
        t_reading r;
        t_code    axis [3];
        logic     to_low;
        int       delta;
        int       total;
        axis[0] = smp.x;
        axis[1] = smp.y;
        axis[2] = smp.z;
        win_pos = 4'((int'(win_pos) + 1) % WIN_LEN);
        to_low  = int'(win_pos) < WIN_LEN / 2;
        for (int i = 0; i < 3; i++) begin
            if (to_low) begin
                low_sum[i] += 13'(axis[i]);
            end else begin
                high_sum[i] += 13'(axis[i]);
            end
        end
        r.activity_valid = 1'b0;
        if (win_pos == '0) begin
            total = 0;
            for (int i = 0; i < 3; i++) begin
                delta = (int'(high_sum[i]) - int'(low_sum[i])) / WIN_LEN / 2;
                total += (delta < 0) ? -delta : delta;
                low_sum[i]  = '0;
                high_sum[i] = '0;
            end
            act_held = (total > int'(ACT_MAX)) ? ACT_MAX : t_act'(total);
            r.activity_valid = 1'b1;
        end
        countdown = countdown - 8'd1;
        if (countdown == '0) begin
            phase     = ~phase;
            duty_held = t_duty'(DUTY_MUL * phase + DUTY_OFF);
            countdown = period;
        end
        r.activity   = act_held;
        r.drive_duty = duty_held;
        return r;
    endfunction

    function automatic t_code pick_code();
        case ($urandom_range(0, 9))
            6:       return '0;
            7:       return CODE_MAX;
            8:       return t_code'(504 + $urandom_range(0, 15));
            9:       return t_code'(1 << $urandom_range(0, SAMPLE_BITS - 1));
            default: return t_code'($urandom_range(0, int'(CODE_MAX)));
        endcase
    endfunction

    task automatic send_sample(input t_sample smp, input logic typed, input t_reading want);
        t_reading predicted;
        sample_if.valid   <= 1'b1;
        sample_if.accel_x <= smp.x;
        sample_if.accel_y <= smp.y;
        sample_if.accel_z <= smp.z;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        predicted = advance_estimator(smp);
        expected_readings.push_back(typed ? want : predicted);
    endtask

    task automatic idle_gap();
        int gap_len;
        gap_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        if (gap_len > 0) begin
            sample_if.valid <= 1'b0;
            repeat (gap_len) @(posedge i_clk);
        end
    endtask

    task automatic run_items(input int count);
        int      sent;
        int      burst;
        t_sample smp;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && sent < count; j++) begin
                smp.x = pick_code();
                smp.y = pick_code();
                smp.z = pick_code();
                send_sample(smp, 1'b0, '0);
                sent++;
            end
            idle_gap();
        end
    endtask

    task automatic drain_readings();
        sample_if.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input t_period value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        period = value;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= PERIOD_RST;
        sample_if.valid   <= 1'b0;
        sample_if.accel_x <= '0;
        sample_if.accel_y <= '0;
        sample_if.accel_z <= '0;
        reset_estimator();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            send_sample(DIRECTED[k].smp, DIRECTED[k].typed, DIRECTED[k].want);
            idle_gap();
        end
        drain_readings();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       write_period(8'd1);
                1:       write_period(8'd255);
                2:       write_period(8'd0);
                4:       write_period(8'd2);
                default: write_period(t_period'($urandom_range(3, 254)));
            endcase
            if (ph == 1) hold_off_req = 1'b1;
            run_items(PHASE_ITEMS);
            drain_readings();
        end

        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Receiver: long hold-off on request, otherwise a changing stall pattern
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(16, 96);
                    stall_pat  = 8'($urandom) | 8'h01;
                end
                mode_left--;
                pat_idx <= pat_idx + 3'd1;
                case (stall_mode)
                    0:       result_if.ready <= 1'b1;
                    1:       result_if.ready <= 1'($urandom_range(0, 1));
                    default: result_if.ready <= stall_pat[pat_idx];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_readings.size() == 0) begin
                $error("result item with no expectation waiting");
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (result_if.activity !== want.activity) begin
                    $error("activity: expected %0d, got %0d", want.activity,
                           result_if.activity);
                    error_count++;
                end
                if (result_if.activity_valid !== want.activity_valid) begin
                    $error("activity_valid: expected %0d, got %0d", want.activity_valid,
                           result_if.activity_valid);
                    error_count++;
                end
                if (result_if.drive_duty !== want.drive_duty) begin
                    $error("drive_duty: expected %0d, got %0d", want.drive_duty,
                           result_if.drive_duty);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
